// ===== hw/rtl/pmp_pkg.sv =====
// ----------------------------------------------------------------------------
// pmp_pkg
// Types, codes and controller states of the path motion profile block.
// ----------------------------------------------------------------------------
package pmp_pkg;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_LANDING = 2'd1,
    REQ_RETURN  = 2'd2,
    REQ_BEGIN   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    MODE_ONCE = 2'd0,
    MODE_LOOP = 2'd1,
    MODE_PING = 2'd2,
    MODE_NONE = 2'd3
  } end_mode_t;

  typedef enum logic [2:0] {
    REG_END_MODE    = 3'd0,
    REG_PATH_LENGTH = 3'd1,
    REG_SPEED_LIMIT = 3'd2,
    REG_ACCEL_RATE  = 3'd3,
    REG_DECEL_RATE  = 3'd4,
    REG_DWELL_TIME  = 3'd5,
    REG_OPTION      = 3'd6
  } reg_index_t;

  localparam int OPT_ZERO_REV  = 0;
  localparam int OPT_ZERO_LOOP = 1;
  localparam int OPT_LANDING   = 2;

  localparam int DT_BITS     = 16;
  localparam int CFG_W       = 31;
  localparam int VALUE_WIDTH = 32;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] delta_time;
    logic        brake;
  } pmp_in_t;

  typedef struct packed {
    logic [30:0]        position;
    logic signed [31:0] speed;
    logic               is_waiting;
    logic               awaiting_landing;
    logic               backward;
  } pmp_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATE,
    ST_SPEED,
    ST_MOVE,
    ST_END,
    ST_OUT
  } pmp_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic rate;
    logic speed;
    logic move;
    logic finish;
  } pmp_cmd_t;

endpackage

// ===== hw/rtl/pmp_ctrl.sv =====
// ----------------------------------------------------------------------------
// pmp_ctrl
// Sequencer: accept a request, step the datapath, hold the result.
// ----------------------------------------------------------------------------
module pmp_ctrl import pmp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output pmp_cmd_t cmd
);

  pmp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_RATE;
      ST_RATE:  state_nxt = ST_SPEED;
      ST_SPEED: state_nxt = ST_MOVE;
      ST_MOVE:  state_nxt = ST_END;
      ST_END:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_ready) state_nxt = in_valid ? ST_RATE : ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state_r == ST_IDLE) || (state_r == ST_OUT && out_ready);
    out_valid  = (state_r == ST_OUT);
    cmd        = '0;
    cmd.load   = in_ready && in_valid;
    cmd.rate   = (state_r == ST_RATE);
    cmd.speed  = (state_r == ST_SPEED);
    cmd.move   = (state_r == ST_MOVE);
    cmd.finish = (state_r == ST_END);
  end

endmodule

// ===== hw/rtl/pmp_dp.sv =====
// ----------------------------------------------------------------------------
// pmp_dp
// Motion datapath: configuration, state, rate and displacement multipliers.
// ----------------------------------------------------------------------------
module pmp_dp import pmp_pkg::*; #(
  parameter int FRAC_BITS   = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  pmp_in_t          in_data,
  input  pmp_cmd_t         cmd,
  output pmp_out_t         out_data
);

  localparam int VW = VALUE_WIDTH;
  localparam int EW = VW + 2;
  localparam logic signed [EW-1:0] VMAX = EW'((65'sd1 <<< (VW - 1)) - 1);

  logic [1:0]       end_mode_r;
  logic [CFG_W-1:0] path_length_r, speed_limit_r, accel_rate_r, decel_rate_r;
  logic [CFG_W-1:0] dwell_time_r;
  logic [2:0]       option_r;

  logic signed [VW-1:0] pos_r, speed_r;
  logic signed [VW:0]   dwell_r;
  logic dir_r, wait_r, land_r;
  logic held_r;

  pmp_in_t item_r;
  logic [CFG_W-1:0] acc_r, dec_r;
  logic signed [EW-1:0] p_r;

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_mode_r    <= '0;
      path_length_r <= '0;
      speed_limit_r <= '0;
      accel_rate_r  <= '0;
      decel_rate_r  <= '0;
      dwell_time_r  <= '0;
      option_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_END_MODE:    end_mode_r    <= cfg_data[1:0];
        REG_PATH_LENGTH: path_length_r <= cfg_data;
        REG_SPEED_LIMIT: speed_limit_r <= cfg_data;
        REG_ACCEL_RATE:  accel_rate_r  <= cfg_data;
        REG_DECEL_RATE:  decel_rate_r  <= cfg_data;
        REG_DWELL_TIME:  dwell_time_r  <= cfg_data;
        REG_OPTION:      option_r      <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Rate products: truncated product of a 31 bit rate and the 16 bit step
  logic [CFG_W+DT_BITS-1:0] acc_full, dec_full;
  assign acc_full = accel_rate_r * item_r.delta_time;
  assign dec_full = decel_rate_r * item_r.delta_time;

  // Speed update
  logic signed [EW-1:0] s, d, a, lim, s_new;
  logic zero_rev;
  always_comb begin
    s        = EW'(speed_r);
    d        = EW'($signed({1'b0, dec_r}));
    a        = EW'($signed({1'b0, acc_r}));
    lim      = EW'($signed({1'b0, speed_limit_r}));
    zero_rev = option_r[OPT_ZERO_REV];
    s_new    = s;
    if (!dir_r) begin
      if (s < 0) begin
        if (zero_rev) s_new = '0;
        else begin
          s_new = s + d;
          if (s_new > 0) s_new = '0;
        end
      end else if (item_r.brake) begin
        s_new = s - d;
        if (s_new < 0) s_new = '0;
      end else begin
        s_new = s + a;
        if (s_new > lim) s_new = lim;
      end
    end else begin
      if (s > 0) begin
        if (zero_rev) s_new = '0;
        else begin
          s_new = s - d;
          if (s_new < 0) s_new = '0;
        end
      end else if (item_r.brake) begin
        s_new = s + d;
        if (s_new > 0) s_new = '0;
      end else begin
        s_new = s - a;
        if (s_new < -lim) s_new = -lim;
      end
    end
    if (s_new > VMAX) s_new = VMAX;
    if (s_new < -VMAX) s_new = -VMAX;
  end

  // Displacement: magnitude times step, truncated, sign restored
  logic [VW-1:0]         mag;
  logic [VW+DT_BITS-1:0] mv_full;
  logic signed [EW-1:0]  step, p_sum;
  always_comb begin
    mag     = speed_r[VW-1] ? VW'(-speed_r) : VW'(speed_r);
    mv_full = mag * item_r.delta_time;
    step    = EW'($signed({2'b00, mv_full[VW+DT_BITS-1:DT_BITS]}));
    if (speed_r[VW-1]) step = -step;
    p_sum   = EW'(pos_r) + step;
  end

  logic signed [EW-1:0] len;
  assign len = EW'($signed({1'b0, path_length_r}));

  logic signed [VW:0] dt_al;
  assign dt_al = (VW+1)'(({{(VW+1){1'b0}}, item_r.delta_time} << FRAC_BITS) >> DT_BITS);

  function automatic logic signed [EW-1:0] clampp(input logic signed [EW-1:0] v,
                                                  input logic signed [EW-1:0] l);
    if (v < 0) return '0;
    if (v > l) return l;
    return v;
  endfunction

  // A tick that found the block waiting moves nothing, even if the dwell ends
  logic room, active;
  assign room   = dir_r ? (pos_r > 0) : (EW'(pos_r) < len);
  assign active = !held_r && end_mode_r != MODE_NONE
                  && (end_mode_r != MODE_ONCE || room);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      speed_r <= '0;
      dwell_r <= '0;
      dir_r   <= 1'b0;
      wait_r  <= 1'b0;
      land_r  <= 1'b0;
      held_r  <= 1'b0;
    end else if (cmd.load) begin
      item_r <= in_data;
      case (req_type_t'(in_data.req_type))
        REQ_LANDING: begin
          if (land_r) begin
            wait_r  <= 1'b0;
            land_r  <= 1'b0;
            dwell_r <= '0;
          end
        end
        REQ_RETURN: pos_r <= '0;
        REQ_BEGIN: begin
          dwell_r <= '0;
          land_r  <= option_r[OPT_LANDING];
          if (option_r[OPT_LANDING]) wait_r <= 1'b1;
        end
        default: ;
      endcase
    end else if (item_r.req_type == REQ_TICK) begin
      if (cmd.rate) begin
        acc_r  <= acc_full[CFG_W+DT_BITS-1:DT_BITS];
        dec_r  <= dec_full[CFG_W+DT_BITS-1:DT_BITS];
        held_r <= wait_r;
        if (wait_r && !land_r) begin
          if (dwell_r - dt_al <= 0) begin
            wait_r  <= 1'b0;
            dwell_r <= '0;
          end else begin
            dwell_r <= dwell_r - dt_al;
          end
        end
      end else if (cmd.speed) begin
        if (active) speed_r <= VW'(s_new);
        else if (!held_r && end_mode_r == MODE_ONCE) speed_r <= '0;
      end else if (cmd.move) begin
        p_r <= p_sum;
      end else if (cmd.finish && active) begin
        case (end_mode_r)
          MODE_ONCE: pos_r <= VW'(clampp(p_r, len));
          MODE_LOOP: begin
            if ((!dir_r && p_r > len) || (dir_r && p_r < 0)) begin
              pos_r <= dir_r ? VW'(len) : '0;
              if (option_r[OPT_ZERO_LOOP]) speed_r <= '0;
              // Park on dwell and/or landing
              wait_r <= (dwell_time_r != '0) || option_r[OPT_LANDING];
              land_r <= option_r[OPT_LANDING];
              if (dwell_time_r != '0) dwell_r <= (VW+1)'(dwell_time_r);
            end else begin
              pos_r <= VW'(clampp(p_r, len));
            end
          end
          MODE_PING: begin
            if (p_r > len || p_r < 0) begin
              pos_r <= (p_r > len) ? VW'(clampp(len - (p_r - len), len))
                                   : VW'(clampp(-p_r, len));
              dir_r <= (p_r > len);
              if (option_r[OPT_ZERO_REV]) speed_r <= '0;
              else if ((p_r > len && speed_r > 0) || (p_r < 0 && speed_r < 0))
                speed_r <= -speed_r;
              wait_r <= (dwell_time_r != '0) || option_r[OPT_LANDING];
              land_r <= option_r[OPT_LANDING];
              if (dwell_time_r != '0) dwell_r <= (VW+1)'(dwell_time_r);
            end else begin
              pos_r <= VW'(p_r);
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    out_data                  = '0;
    out_data.position         = pos_r[30:0];
    out_data.speed            = 32'(speed_r);
    out_data.is_waiting       = wait_r;
    out_data.awaiting_landing = land_r;
    out_data.backward         = dir_r;
  end

endmodule

// ===== hw/rtl/path_motion_profile.sv =====
// ----------------------------------------------------------------------------
// path_motion_profile
// Trapezoidal speed profile that moves a point along a path of set length.
// ----------------------------------------------------------------------------
// Usage:
//   Send one request per step on in_*: a tick (advance by delta_time),
//   a landing event, return to start, or begin. Every request yields exactly
//   one result on out_* with position, signed speed and the wait and
//   direction flags as they stand after that request.
//   Each request runs through rate products, speed update, displacement
//   product and end handling in that order before out_valid rises; a new
//   request is taken only once the previous result has been taken.
//   The result is held in the state registers; in_ready rises again in the
//   cycle the result is taken, so the next request enters at once.
//   When the receiver stalls, hold the result and accept nothing new.
//   Reset (rst_n low at a clock edge) clears the configuration, motion state
//   and sequencer: the point sits at zero, at rest, moving forward, not waiting.
//   Write configuration on cfg_* only while the block is idle.
// ----------------------------------------------------------------------------
module path_motion_profile import pmp_pkg::*; #(
  parameter int FRAC_BITS   = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  pmp_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output pmp_out_t         out_data
);

  pmp_cmd_t cmd;

  // Sequence each request through the datapath
  pmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Hold state and do the arithmetic
  pmp_dp #(
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule

// ===== tb/path_motion_profile_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// path_motion_profile_test
// Drives move, landing, return and begin requests through the motion block
// under several path and rate settings, predicts every result in step with
// the block and compares each one as it leaves, with random idling on both
// sides and one long output hold-off.
// ----------------------------------------------------------------------------
module path_motion_profile_test;
  import pmp_pkg::*;

  localparam longint SPEED_MAX = 64'sh7FFF_FFFF;
  localparam int WATCHDOG_LIMIT = 20000;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [2:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  pmp_in_t          in_data;
  logic             out_valid;
  logic             out_ready;
  pmp_out_t         out_data;

  path_motion_profile dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Predictor copy of configuration and state
  logic [1:0]  m_mode;
  longint      m_len, m_lim, m_acc, m_dec, m_dwell;
  logic [2:0]  m_opt;
  longint      m_pos, m_spd, m_dwell_left;
  bit          m_back, m_wait, m_land;

  pmp_out_t    expected_q[$];
  int          fail_count = 0;
  bit          idle_on = 1;
  int          out_idle = 0;
  int          stall_cycles = 0;

  initial clk = 0;
  always #2 clk = ~clk;

  function automatic longint scale_dt(longint v, int dt);
    longint mag;
    mag = v < 0 ? -v : v;
    mag = (mag * dt) >>> DT_BITS;
    return v < 0 ? -mag : mag;
  endfunction

  function automatic longint clamp_path(longint p);
    if (p < 0) return 0;
    if (p > m_len) return m_len;
    return p;
  endfunction

  function automatic void ramp_speed(int dt, bit brake);
    longint s, d, a;
    s = m_spd;
    d = scale_dt(m_dec, dt);
    a = scale_dt(m_acc, dt);
    if (!m_back) begin
      if (s < 0) begin
        if (m_opt[OPT_ZERO_REV]) s = 0;
        else begin s += d; if (s > 0) s = 0; end
      end else if (brake) begin
        s -= d; if (s < 0) s = 0;
      end else begin
        s += a; if (s > m_lim) s = m_lim;
      end
    end else begin
      if (s > 0) begin
        if (m_opt[OPT_ZERO_REV]) s = 0;
        else begin s -= d; if (s < 0) s = 0; end
      end else if (brake) begin
        s += d; if (s > 0) s = 0;
      end else begin
        s -= a; if (s < -m_lim) s = -m_lim;
      end
    end
    if (s > SPEED_MAX) s = SPEED_MAX;
    if (s < -SPEED_MAX) s = -SPEED_MAX;
    m_spd = s;
  endfunction

  // Park at a path end on dwell and/or landing
  function automatic void park_at_end();
    if (m_dwell > 0) begin
      m_wait = 1; m_dwell_left = m_dwell; m_land = 0;
    end
    if (m_opt[OPT_LANDING]) begin
      m_wait = 1; m_land = 1;
    end
  endfunction

  function automatic void advance_tick(int dt, bit brake);
    longint p;
    if (m_wait) begin
      if (m_land) return;
      m_dwell_left -= dt;
      if (m_dwell_left <= 0) begin m_wait = 0; m_dwell_left = 0; end
      return;
    end
    case (end_mode_t'(m_mode))
      MODE_ONCE: begin
        if (m_back ? (m_pos > 0) : (m_pos < m_len)) begin
          ramp_speed(dt, brake);
          m_pos = clamp_path(m_pos + scale_dt(m_spd, dt));
        end else begin
          m_spd = 0;
        end
      end
      MODE_LOOP: begin
        ramp_speed(dt, brake);
        p = m_pos + scale_dt(m_spd, dt);
        if ((!m_back && p > m_len) || (m_back && p < 0)) begin
          p = m_back ? m_len : 0;
          if (m_opt[OPT_ZERO_LOOP]) m_spd = 0;
          park_at_end();
        end
        m_pos = clamp_path(p);
      end
      MODE_PING: begin
        ramp_speed(dt, brake);
        p = m_pos + scale_dt(m_spd, dt);
        if (p > m_len) begin
          p = m_len - (p - m_len);
          m_back = 1;
          if (m_opt[OPT_ZERO_REV]) m_spd = 0;
          else if (m_spd > 0) m_spd = -m_spd;
          park_at_end();
        end else if (p < 0) begin
          p = -p;
          m_back = 0;
          if (m_opt[OPT_ZERO_REV]) m_spd = 0;
          else if (m_spd < 0) m_spd = -m_spd;
          park_at_end();
        end
        m_pos = clamp_path(p);
      end
      default: ;
    endcase
  endfunction

  function automatic pmp_out_t predict_motion(pmp_in_t r);
    pmp_out_t o;
    case (req_type_t'(r.req_type))
      REQ_TICK: advance_tick(r.delta_time, r.brake);
      REQ_LANDING: begin
        if (m_land) begin m_wait = 0; m_land = 0; m_dwell_left = 0; end
      end
      REQ_RETURN: m_pos = 0;
      default: begin
        m_dwell_left = 0;
        m_land = 0;
        if (m_opt[OPT_LANDING]) begin m_wait = 1; m_land = 1; end
      end
    endcase
    o.position = m_pos[30:0];
    o.speed = m_spd[31:0];
    o.is_waiting = m_wait;
    o.awaiting_landing = m_land;
    o.backward = m_back;
    return o;
  endfunction

  // Send one request; the expectation is computed when it is accepted.
  // Valid drops only for idling or when the stream ends.
  task automatic send_request(req_type_t kind, int dt, bit brake);
    pmp_in_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    r.req_type = kind;
    r.delta_time = dt[15:0];
    r.brake = brake;
    in_valid <= 1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(predict_motion(r));
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, longint value);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_END_MODE:    m_mode = value[1:0];
      REG_PATH_LENGTH: m_len = value[30:0];
      REG_SPEED_LIMIT: m_lim = value[30:0];
      REG_ACCEL_RATE:  m_acc = value[30:0];
      REG_DECEL_RATE:  m_dec = value[30:0];
      REG_DWELL_TIME:  m_dwell = value[30:0];
      default:         m_opt = value[2:0];
    endcase
  endtask

  task automatic configure(end_mode_t mode, longint len, longint lim, longint acc,
                           longint dec, longint dwell, int opt);
    drain();
    write_reg(REG_END_MODE, mode);
    write_reg(REG_PATH_LENGTH, len);
    write_reg(REG_SPEED_LIMIT, lim);
    write_reg(REG_ACCEL_RATE, acc);
    write_reg(REG_DECEL_RATE, dec);
    write_reg(REG_DWELL_TIME, dwell);
    write_reg(REG_OPTION, opt);
  endtask

  // Mostly ticks with random dt; landing follows parking often enough
  task automatic send_random_mix(int n, bit wide);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (m_land && r < 40) send_request(REQ_LANDING, $urandom, 1'($urandom));
      else if (r < 85)
        send_request(REQ_TICK, wide ? $urandom : $urandom_range(0, 8192), $urandom_range(0, 3) == 0);
      else if (r < 91) send_request(REQ_LANDING, $urandom, 1'($urandom));
      else if (r < 95) send_request(REQ_RETURN, $urandom, 1'($urandom));
      else send_request(REQ_BEGIN, $urandom, 1'($urandom));
    end
  endtask

  task automatic test_directed();
    configure(MODE_ONCE, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 0, 0);
    send_request(REQ_TICK, 16'hFFFF, 0);
    send_request(REQ_TICK, 16'hFFFF, 0);
    send_request(REQ_TICK, 16'hFFFF, 0);
    send_request(REQ_TICK, 16'hFFFF, 1);
    send_request(REQ_TICK, 0, 0);
    send_request(REQ_RETURN, 0, 0);
    send_request(REQ_LANDING, 0, 0);
    send_request(REQ_BEGIN, 0, 0);
    // Unused end mode: ticks move nothing
    configure(MODE_NONE, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 0, 0);
    send_request(REQ_TICK, 16'hFFFF, 0);
    // Extreme rates and limit, large path, ping-pong with landing wait
    configure(MODE_PING, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 7);
    for (int i = 0; i < 6; i++) send_request(REQ_TICK, 16'hFFFF, 0);
    send_request(REQ_LANDING, 0, 0);
    send_request(REQ_BEGIN, 16'hFFFF, 1);
    send_request(REQ_LANDING, 16'hFFFF, 1);
    // Shortened path while beyond it: clamps
    configure(MODE_LOOP, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h0000_0100, 2);
    send_request(REQ_TICK, 1, 0);
    send_request(REQ_TICK, 16'hFFFF, 0);
    send_request(REQ_TICK, 16'hFFFF, 0);
  endtask

  task automatic test_ping_pong();
    configure(MODE_PING, 32'h0010_0000, 32'h0008_0000, 32'h0004_0000, 32'h0010_0000,
              32'h0000_4000, 0);
    send_random_mix(300, 0);
    configure(MODE_PING, 32'h0001_0000, 32'h0040_0000, 32'h0100_0000, 32'h0000_8000, 0, 1);
    send_random_mix(250, 1);
  endtask

  task automatic test_loop();
    configure(MODE_LOOP, 32'h0020_0000, 32'h0010_0000, 32'h0008_0000, 32'h0004_0000,
              32'h0001_0000, 6);
    send_random_mix(300, 0);
    configure(MODE_LOOP, 32'h0008_0000, 32'h0004_0000, 32'h0002_0000, 32'h0002_0000, 0, 3);
    send_random_mix(250, 1);
  endtask

  task automatic test_once();
    configure(MODE_ONCE, 32'h0010_0000, 32'h0006_0000, 32'h0003_0000, 32'h0001_0000, 0, 1);
    send_random_mix(200, 0);
  endtask

  // Hold the output for a long stretch while requests keep coming
  task automatic test_backpressure();
    configure(MODE_PING, 32'h0010_0000, 32'h0008_0000, 32'h0004_0000, 32'h0002_0000, 0, 0);
    stall_cycles = 200;
    send_random_mix(100, 0);
  endtask

  task automatic test_random_settings();
    for (int k = 0; k < 5; k++) begin
      configure(end_mode_t'($urandom_range(0, 3)), $urandom_range(0, 32'h0040_0000),
                $urandom_range(0, 32'h0020_0000), $urandom_range(0, 32'h0010_0000),
                $urandom_range(0, 32'h0010_0000), $urandom_range(0, 32'h0000_8000),
                $urandom_range(0, 7));
      send_random_mix(100, k[0]);
    end
    // Last part runs with no idling at all
    idle_on = 0;
    configure(MODE_PING, 32'h0010_0000, 32'h0008_0000, 32'h0004_0000, 32'h0002_0000, 0, 0);
    send_random_mix(150, 0);
  endtask

  // Output side: short random stalls, and the long hold-off
  always @(posedge clk) begin
    if (stall_cycles > 0) begin
      stall_cycles <= stall_cycles - 1;
      out_ready <= 0;
    end else if (out_idle > 0) begin
      out_idle <= out_idle - 1;
      out_ready <= 0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_idle <= $urandom_range(0, 2);
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    pmp_out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, out_data);
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        if (out_data.position !== e.position) begin
          $display("%0t: position exp %h got %h", $realtime, e.position, out_data.position);
          fail_count++;
        end
        if (out_data.speed !== e.speed) begin
          $display("%0t: speed exp %h got %h", $realtime, e.speed, out_data.speed);
          fail_count++;
        end
        if (out_data.is_waiting !== e.is_waiting) begin
          $display("%0t: is_waiting exp %b got %b", $realtime, e.is_waiting,
                   out_data.is_waiting);
          fail_count++;
        end
        if (out_data.awaiting_landing !== e.awaiting_landing) begin
          $display("%0t: awaiting_landing exp %b got %b", $realtime, e.awaiting_landing,
                   out_data.awaiting_landing);
          fail_count++;
        end
        if (out_data.backward !== e.backward) begin
          $display("%0t: backward exp %b got %b", $realtime, e.backward, out_data.backward);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: cycles with no request or result accepted
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("path_motion_profile_test: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 0;
    cfg_we = 0;
    cfg_index = REG_END_MODE;
    cfg_data = '0;
    in_valid = 0;
    in_data = '0;
    out_ready = 0;
    m_mode = MODE_ONCE; m_len = 0; m_lim = 0; m_acc = 0; m_dec = 0; m_dwell = 0; m_opt = 0;
    m_pos = 0; m_spd = 0; m_dwell_left = 0; m_back = 0; m_wait = 0; m_land = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_ping_pong();
    test_loop();
    test_once();
    test_backpressure();
    test_random_settings();
    drain();
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("path_motion_profile_test: PASS");
    end else begin
      $display("path_motion_profile_test: FAIL");
    end
    $finish;
  end

endmodule
